### rtl/button_auto_repeat_macros.svh
// Assertion macros used by the auto-repeat core.
`ifndef BUTTON_AUTO_REPEAT_MACROS_SVH
`define BUTTON_AUTO_REPEAT_MACROS_SVH

`ifndef SYNTHESIS

// Property that must hold at every clock edge outside reset.
`define BAR_ASSERT_ALWAYS(label, expr) \
   label: assert property (@(posedge clock) disable iff (reset) (expr)) \
      else $error("assertion failed: invariant");

// Antecedent in one cycle implies the consequent in the next.
`define BAR_ASSERT_NEXT(label, ante, cons) \
   label: assert property (@(posedge clock) disable iff (reset) (ante) |=> (cons)) \
      else $error("assertion failed: next-cycle implication");

`else

`define BAR_ASSERT_ALWAYS(label, expr)
`define BAR_ASSERT_NEXT(label, ante, cons)

`endif

`endif

### rtl/bar_pkg.sv
package bar_pkg;

   localparam int MaskW   = 8;
   localparam int IndexW  = 3;
   localparam int RegW    = 16;
   localparam int CntW    = 17;
   localparam int CsrIdxW = 1;

   localparam logic [RegW-1:0] DelayReset    = 16'd30;
   localparam logic [RegW-1:0] IntervalReset = 16'd0;

   typedef enum logic [CsrIdxW-1:0] {
      CSR_REPEAT_DELAY    = 1'b0,
      CSR_REPEAT_INTERVAL = 1'b1
   } csr_index_type;

   // Outcome of the priority search over one item's pressed mask.
   typedef struct packed {
      logic              found;
      logic [IndexW-1:0] index;
   } win_type;

endpackage

### rtl/button_auto_repeat.sv
// Channel   | Handshake            | Payload
// req_      | req_valid/req_stall  | req_pressed_mask[7:0]
// rsp_      | rsp_valid/rsp_stall  | rsp_push_valid, rsp_push_index[2:0], rsp_repeat_total[15:0]
// csr_      | csr_write_enable     | csr_index, csr_write_data[15:0]
//
// One item per cycle sustained while rsp_stall is low; an item accepted into the
// input register moves into the result register once that register is free.
// Synchronous reset clears the held button, the counters and both registers to
// their reset values (delay 30, interval 0).
// A stalled result holds the input register, which then raises req_stall.
module button_auto_repeat import bar_pkg::*; #(
   parameter int NUM_BUTTONS = 8
) (
   input  logic               clock,
   input  logic               reset,
   input  logic               req_valid,
   output logic               req_stall,
   input  logic [MaskW-1:0]   req_pressed_mask,
   output logic               rsp_valid,
   input  logic               rsp_stall,
   output logic               rsp_push_valid,
   output logic [IndexW-1:0]  rsp_push_index,
   output logic [RegW-1:0]    rsp_repeat_total,
   input  logic               csr_write_enable,
   input  logic [CsrIdxW-1:0] csr_index,
   input  logic [RegW-1:0]    csr_write_data
);

   logic             in_valid_ff, in_valid_in;
   logic [MaskW-1:0] in_mask_ff;
   logic             out_free;
   logic             advance;
   logic             req_take;
   win_type          win;

   assign out_free  = !rsp_valid || !rsp_stall;
   assign advance   = in_valid_ff && out_free;
   assign req_stall = in_valid_ff && !out_free;
   assign req_take  = req_valid && !req_stall;

   always_comb begin
      in_valid_in = in_valid_ff;
      if (req_take) begin
         in_valid_in = 1'b1;
      end else if (advance) begin
         in_valid_in = 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         in_valid_ff <= 1'b0;
      end else begin
         in_valid_ff <= in_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      if (req_take) begin
         in_mask_ff <= req_pressed_mask;
      end
   end

   bar_encoder #(
      .NUM_BUTTONS (NUM_BUTTONS)
   ) u_encoder (
      .pressed_mask (in_mask_ff),
      .win          (win)
   );

   bar_core u_core (
      .clock            (clock),
      .reset            (reset),
      .csr_write_enable (csr_write_enable),
      .csr_index        (csr_index),
      .csr_write_data   (csr_write_data),
      .item_valid       (advance),
      .win              (win),
      .rsp_stall        (rsp_stall),
      .rsp_valid        (rsp_valid),
      .rsp_push_valid   (rsp_push_valid),
      .rsp_push_index   (rsp_push_index),
      .rsp_repeat_total (rsp_repeat_total)
   );

endmodule

### rtl/bar_encoder.sv
module bar_encoder import bar_pkg::*; #(
   parameter int NUM_BUTTONS = 8
) (
   input  logic [MaskW-1:0] pressed_mask,
   output win_type          win
);

   // Buttons beyond the mask width cannot be seen.
   localparam int UsedBits = (NUM_BUTTONS < MaskW) ? NUM_BUTTONS : MaskW;

   // The highest pressed index wins, so later bits override earlier ones.
   always_comb begin
      win.found = 1'b0;
      win.index = '0;
      for (int i = 0; i < UsedBits; i++) begin
         if (pressed_mask[i]) begin
            win.found = 1'b1;
            win.index = IndexW'(i);
         end
      end
   end

endmodule

### rtl/bar_core.sv
`include "button_auto_repeat_macros.svh"

module bar_core import bar_pkg::*; (
   input  logic              clock,
   input  logic              reset,
   input  logic              csr_write_enable,
   input  logic [CsrIdxW-1:0] csr_index,
   input  logic [RegW-1:0]   csr_write_data,
   input  logic              item_valid,
   input  win_type           win,
   input  logic              rsp_stall,
   output logic              rsp_valid,
   output logic              rsp_push_valid,
   output logic [IndexW-1:0] rsp_push_index,
   output logic [RegW-1:0]   rsp_repeat_total
);

   localparam logic [CntW-1:0] CntOne = CntW'(1);
   localparam logic [RegW-1:0] RegMax = '1;

   logic [RegW-1:0]   repeat_delay_ff, repeat_delay_in;
   logic [RegW-1:0]   repeat_interval_ff, repeat_interval_in;
   logic              held_valid_ff, held_valid_in;
   logic [IndexW-1:0] held_index_ff, held_index_in;
   logic              phase_ff, phase_in;
   logic [CntW-1:0]   delay_cnt_ff, delay_cnt_in;
   logic [CntW-1:0]   interval_cnt_ff, interval_cnt_in;
   logic [RegW-1:0]   repeat_cnt_ff, repeat_cnt_in;
   logic              rsp_valid_ff, rsp_valid_in;
   logic              push_ff, push_in;
   logic [IndexW-1:0] push_index_ff, push_index_in;
   logic [RegW-1:0]   total_ff;
   logic [CntW-1:0]   delay_dec, interval_dec;

   assign delay_dec    = delay_cnt_ff - CntOne;
   assign interval_dec = interval_cnt_ff - CntOne;

   always_comb begin
      repeat_delay_in    = repeat_delay_ff;
      repeat_interval_in = repeat_interval_ff;
      if (csr_write_enable) begin
         unique case (csr_index_type'(csr_index))
            CSR_REPEAT_DELAY:    repeat_delay_in    = csr_write_data;
            CSR_REPEAT_INTERVAL: repeat_interval_in = csr_write_data;
            default:             repeat_delay_in    = repeat_delay_ff;
         endcase
      end
   end

   always_comb begin
      held_valid_in   = held_valid_ff;
      held_index_in   = held_index_ff;
      phase_in        = phase_ff;
      delay_cnt_in    = delay_cnt_ff;
      interval_cnt_in = interval_cnt_ff;
      repeat_cnt_in   = repeat_cnt_ff;
      push_in         = 1'b0;
      push_index_in   = '0;
      if (win.found) begin
         if (held_valid_ff && (win.index == held_index_ff)) begin
            if (phase_ff) begin
               interval_cnt_in = interval_dec;
               if (interval_dec == '0) begin
                  interval_cnt_in = {1'b0, repeat_interval_ff} + CntOne;
                  if (repeat_cnt_ff != RegMax) begin
                     repeat_cnt_in = repeat_cnt_ff + RegW'(1);
                  end
                  push_in       = 1'b1;
                  push_index_in = win.index;
               end
            end else begin
               delay_cnt_in = delay_dec;
               if (delay_dec == '0) begin
                  interval_cnt_in = CntOne;
                  phase_in        = 1'b1;
               end
            end
         end else begin
            // A new winner pushes at once and restarts the delay.
            delay_cnt_in  = {1'b0, repeat_delay_ff} + CntOne;
            phase_in      = 1'b0;
            repeat_cnt_in = '0;
            push_in       = 1'b1;
            push_index_in = win.index;
         end
         held_valid_in = 1'b1;
         held_index_in = win.index;
      end else begin
         phase_in      = 1'b0;
         held_valid_in = 1'b0;
         held_index_in = '0;
      end
   end

   // The result register is refilled by each new item and empties once taken.
   always_comb begin
      rsp_valid_in = rsp_valid_ff;
      if (item_valid) begin
         rsp_valid_in = 1'b1;
      end else if (!rsp_stall) begin
         rsp_valid_in = 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         repeat_delay_ff    <= DelayReset;
         repeat_interval_ff <= IntervalReset;
         held_valid_ff      <= 1'b0;
         held_index_ff      <= '0;
         phase_ff           <= 1'b0;
         delay_cnt_ff       <= '0;
         interval_cnt_ff    <= '0;
         repeat_cnt_ff      <= '0;
         rsp_valid_ff       <= 1'b0;
      end else begin
         repeat_delay_ff    <= repeat_delay_in;
         repeat_interval_ff <= repeat_interval_in;
         rsp_valid_ff       <= rsp_valid_in;
         if (item_valid) begin
            held_valid_ff   <= held_valid_in;
            held_index_ff   <= held_index_in;
            phase_ff        <= phase_in;
            delay_cnt_ff    <= delay_cnt_in;
            interval_cnt_ff <= interval_cnt_in;
            repeat_cnt_ff   <= repeat_cnt_in;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (item_valid) begin
         push_ff       <= push_in;
         push_index_ff <= push_index_in;
         total_ff      <= repeat_cnt_in;
      end
   end

   assign rsp_valid        = rsp_valid_ff;
   assign rsp_push_valid   = push_ff;
   assign rsp_push_index   = push_index_ff;
   assign rsp_repeat_total = total_ff;

   `BAR_ASSERT_ALWAYS(a_phase_needs_held, !phase_ff || held_valid_ff)
   `BAR_ASSERT_ALWAYS(a_delay_live, !held_valid_ff || phase_ff || (delay_cnt_ff != '0))
   `BAR_ASSERT_ALWAYS(a_interval_live, !phase_ff || (interval_cnt_ff != '0))
   `BAR_ASSERT_NEXT(a_item_lands, item_valid, rsp_valid_ff)

endmodule
